@@ hdl/pta_pkg.sv @@
// shared constants and entry types for the per-symbol trade aggregator
`timescale 1ns / 1ps
`default_nettype none

package pta_pkg;

   // table size and derived widths
   localparam int MAX_SYMBOLS = 1024;
   localparam int SLOT_W      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int USED_W      = $clog2(MAX_SYMBOLS + 1);
   localparam int DIR_AW      = $clog2(MAX_SYMBOLS) + 1;
   localparam int DIR_DEPTH   = 1 << DIR_AW;

   // field widths
   localparam int TIME_W     = 48;
   localparam int KEY_W      = 24;
   localparam int QTY_W      = 32;
   localparam int PRICE_W    = 32;
   localparam int VOL_W      = 48;
   localparam int NOTIONAL_W = 64;
   localparam int RSP_SLOT_W = 10;

   // directory entry: ticker key and the slot that holds its statistics
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } dir_entry_type;

   // statistics entry of one symbol
   typedef struct packed {
      logic [TIME_W-1:0]     last_seen;
      logic [TIME_W-1:0]     gap;
      logic [VOL_W-1:0]      volume;
      logic [PRICE_W-1:0]    peak;
      logic [NOTIONAL_W-1:0] notional;
      logic                  ovf;
   } stat_entry_type;

endpackage

`default_nettype wire

@@ hdl/pta_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/pta_stat_update.sv @@
// statistics update of one known symbol for one trade
`timescale 1ns / 1ps
`default_nettype none

module pta_stat_update (
   input  pta_pkg::stat_entry_type            cur,
   input  logic [pta_pkg::TIME_W-1:0]         trade_time,
   input  logic [pta_pkg::QTY_W-1:0]          quantity,
   input  logic [pta_pkg::PRICE_W-1:0]        unit_price,
   input  logic [pta_pkg::NOTIONAL_W-1:0]     product,
   output pta_pkg::stat_entry_type            nxt
);
   import pta_pkg::*;

   logic [TIME_W-1:0]   gap;
   logic [VOL_W:0]      vol_sum;
   logic [NOTIONAL_W:0] notional_sum;

   // gap, saturating sums and peak
   always_comb begin
      gap          = (trade_time >= cur.last_seen) ? (trade_time - cur.last_seen) : '0;
      vol_sum      = {1'b0, cur.volume} + (VOL_W + 1)'(quantity);
      notional_sum = {1'b0, cur.notional} + {1'b0, product};

      nxt.last_seen = trade_time;
      nxt.gap       = (gap > cur.gap) ? gap : cur.gap;
      nxt.volume    = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
      nxt.peak      = (unit_price > cur.peak) ? unit_price : cur.peak;
      nxt.notional  = notional_sum[NOTIONAL_W] ? '1 : notional_sum[NOTIONAL_W-1:0];
      nxt.ovf       = cur.ovf | vol_sum[VOL_W] | notional_sum[NOTIONAL_W];
   end

endmodule

`default_nettype wire

@@ hdl/per_symbol_trade_aggregator.sv @@
// top level: symbol directory lookup, statistics read-modify-write, result word
`timescale 1ns / 1ps
`default_nettype none

// Per-symbol trade statistics.
// A trade word is taken at a rising edge with start high and busy low. Its
// ticker is hashed into a directory ram of 2^(clog2(MAX_SYMBOLS)+1) entries
// and probed linearly, one entry per cycle, until the ticker or a free entry
// is found. A new ticker takes the next free slot of the statistics ram, or
// is dropped when the table is full; a known one has its slot read, updated
// and written back. Exactly one result word per trade, shown for one cycle
// with rsp_strobe. The word is registered from the last probe for a new or
// dropped ticker and from the write-back for a known one; busy stays high
// until it is made, so no new trade is taken while one is in progress.
// After reset the directory valid bits are cleared in one pass over all
// DIR_DEPTH entries (2048 at 1024 symbols) with busy high; the table
// starts empty.
// The receiver cannot stall; a result is lost if not taken in its cycle.
module per_symbol_trade_aggregator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pta_pkg::TIME_W-1:0]          req_trade_time,
   input  logic [pta_pkg::KEY_W-1:0]           req_ticker,
   input  logic [pta_pkg::QTY_W-1:0]           req_quantity,
   input  logic [pta_pkg::PRICE_W-1:0]         req_unit_price,
   output logic                                rsp_strobe,
   output logic [pta_pkg::RSP_SLOT_W-1:0]      rsp_slot,
   output logic                                rsp_inserted,
   output logic                                rsp_dropped,
   output logic [pta_pkg::TIME_W-1:0]          rsp_gap_max,
   output logic [pta_pkg::VOL_W-1:0]           rsp_volume_sum,
   output logic [pta_pkg::PRICE_W-1:0]         rsp_price_peak,
   output logic [pta_pkg::NOTIONAL_W-1:0]      rsp_notional_sum,
   output logic                                rsp_overflowed
);
   import pta_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_UPD} state_type;

   typedef struct packed {
      logic                  strobe;
      logic [RSP_SLOT_W-1:0] slot;
      logic                  inserted;
      logic                  dropped;
      logic [TIME_W-1:0]     gap;
      logic [VOL_W-1:0]      volume;
      logic [PRICE_W-1:0]    peak;
      logic [NOTIONAL_W-1:0] notional;
      logic                  ovf;
   } rsp_type;

   localparam logic [KEY_W-1:0] HASH_MULT = 24'h9E3779;

   // multiplicative hash, top bits of the low product word
   function automatic logic [DIR_AW-1:0] hash_key(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] m;
      m = KEY_W'(key * HASH_MULT);
      return m[KEY_W-1 -: DIR_AW];
   endfunction

   state_type               state_ff, state_in;
   logic [DIR_AW-1:0]       clr_ff, clr_in;
   logic [USED_W-1:0]       used_ff, used_in;
   logic [DIR_AW-1:0]       probe_ff, probe_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [QTY_W-1:0]        qty_ff, qty_in;
   logic [PRICE_W-1:0]      price_ff, price_in;
   logic [NOTIONAL_W-1:0]   prod_ff, prod_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    dir_we;
   logic [DIR_AW-1:0]       dir_waddr;
   dir_entry_type           dir_wdata;
   logic [DIR_AW-1:0]       dir_raddr;
   dir_entry_type           dir_q;

   logic                    stat_we;
   logic [SLOT_W-1:0]       stat_waddr;
   stat_entry_type          stat_wdata;
   logic [SLOT_W-1:0]       stat_raddr;
   stat_entry_type          stat_q;
   stat_entry_type          stat_new;

   logic                    hit;
   logic                    full;
   logic [QTY_W+PRICE_W-1:0] mul;

   // directory: key to slot, linear probing
   pta_ram #(.WIDTH($bits(dir_entry_type)), .DEPTH(DIR_DEPTH)) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_addr (dir_raddr),
      .rd_data (dir_q)
   );

   // per-slot statistics
   pta_ram #(.WIDTH($bits(stat_entry_type)), .DEPTH(MAX_SYMBOLS)) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_waddr),
      .wr_data (stat_wdata),
      .rd_addr (stat_raddr),
      .rd_data (stat_q)
   );

   pta_stat_update u_stat_update (
      .cur        (stat_q),
      .trade_time (time_ff),
      .quantity   (qty_ff),
      .unit_price (price_ff),
      .product    (prod_ff),
      .nxt        (stat_new)
   );

   assign mul  = req_quantity * req_unit_price;
   assign hit  = dir_q.valid && (dir_q.key == key_ff);
   assign full = (used_ff == USED_W'(MAX_SYMBOLS));

   // next state, ram control and result word
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      used_in  = used_ff;
      probe_in = probe_ff;
      slot_in  = slot_ff;
      time_in  = time_ff;
      key_in   = key_ff;
      qty_in   = qty_ff;
      price_in = price_ff;
      prod_in  = prod_ff;
      rsp_in        = rsp_ff;
      rsp_in.strobe = 1'b0;

      dir_we    = 1'b0;
      dir_waddr = probe_ff;
      dir_wdata = '0;
      dir_raddr = probe_ff + 1'b1;

      stat_we    = 1'b0;
      stat_waddr = slot_ff;
      stat_wdata = stat_new;
      stat_raddr = dir_q.slot;

      case (state_ff)
         ST_CLEAR: begin
            dir_we    = 1'b1;
            dir_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            dir_raddr = hash_key(req_ticker);
            if (start) begin
               time_in  = req_trade_time;
               key_in   = req_ticker;
               qty_in   = req_quantity;
               price_in = req_unit_price;
               prod_in  = mul;
               probe_in = hash_key(req_ticker);
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (hit) begin
               // known symbol: fetch its statistics
               slot_in  = dir_q.slot;
               state_in = ST_UPD;
            end else if (!dir_q.valid) begin
               rsp_in.strobe = 1'b1;
               state_in      = ST_IDLE;
               if (full) begin
                  // table full: trade ignored
                  rsp_in          = '0;
                  rsp_in.strobe   = 1'b1;
                  rsp_in.dropped  = 1'b1;
               end else begin
                  // new symbol: claim directory entry and next slot
                  dir_we          = 1'b1;
                  dir_waddr       = probe_ff;
                  dir_wdata.valid = 1'b1;
                  dir_wdata.key   = key_ff;
                  dir_wdata.slot  = used_ff[SLOT_W-1:0];

                  stat_we              = 1'b1;
                  stat_waddr           = used_ff[SLOT_W-1:0];
                  stat_wdata.last_seen = time_ff;
                  stat_wdata.gap       = '0;
                  stat_wdata.volume    = VOL_W'(qty_ff);
                  stat_wdata.peak      = price_ff;
                  stat_wdata.notional  = prod_ff;
                  stat_wdata.ovf       = 1'b0;

                  used_in         = used_ff + 1'b1;
                  rsp_in.slot     = RSP_SLOT_W'(used_ff);
                  rsp_in.inserted = 1'b1;
                  rsp_in.dropped  = 1'b0;
                  rsp_in.gap      = '0;
                  rsp_in.volume   = VOL_W'(qty_ff);
                  rsp_in.peak     = price_ff;
                  rsp_in.notional = prod_ff;
                  rsp_in.ovf      = 1'b0;
               end
            end else begin
               // occupied by another symbol: next entry
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_UPD: begin
            // write back and report
            stat_we         = 1'b1;
            stat_waddr      = slot_ff;
            stat_wdata      = stat_new;
            rsp_in.strobe   = 1'b1;
            rsp_in.slot     = RSP_SLOT_W'(slot_ff);
            rsp_in.inserted = 1'b0;
            rsp_in.dropped  = 1'b0;
            rsp_in.gap      = stat_new.gap;
            rsp_in.volume   = stat_new.volume;
            rsp_in.peak     = stat_new.peak;
            rsp_in.notional = stat_new.notional;
            rsp_in.ovf      = stat_new.ovf;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         used_ff       <= '0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
         probe_ff <= probe_in;
         slot_ff  <= slot_in;
         time_ff  <= time_in;
         key_ff   <= key_in;
         qty_ff   <= qty_in;
         price_ff <= price_in;
         prod_ff  <= prod_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_ff.strobe;
   assign rsp_slot         = rsp_ff.slot;
   assign rsp_inserted     = rsp_ff.inserted;
   assign rsp_dropped      = rsp_ff.dropped;
   assign rsp_gap_max      = rsp_ff.gap;
   assign rsp_volume_sum   = rsp_ff.volume;
   assign rsp_price_peak   = rsp_ff.peak;
   assign rsp_notional_sum = rsp_ff.notional;
   assign rsp_overflowed   = rsp_ff.ovf;

   // a new trade must pass ST_IDLE and ST_LOOK before its result, so strobes never abut
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe high in two consecutive cycles");

   // fill count stays within the table
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(MAX_SYMBOLS))
      else $error("slot count beyond table size");

   // an inserted word claims exactly one new slot
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_inserted) |-> (used_ff == $past(used_ff) + 1'b1))
      else $error("insert did not advance slot count by one");

   // a drop only with a full table and never together with an insert
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_dropped) |-> (full && !rsp_inserted))
      else $error("trade dropped while table not full");

endmodule

`default_nettype wire

@@ tb/sv/per_symbol_trade_aggregator_checker.sv @@
// scoreboard for the trade aggregator: per-symbol statistics prediction and result compare
`timescale 1ns / 1ps

module per_symbol_trade_aggregator_checker
   import pta_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [TIME_W-1:0]     req_trade_time,
   input  logic [KEY_W-1:0]      req_ticker,
   input  logic [QTY_W-1:0]      req_quantity,
   input  logic [PRICE_W-1:0]    req_unit_price,
   input  logic                  rsp_strobe,
   input  logic [RSP_SLOT_W-1:0] rsp_slot,
   input  logic                  rsp_inserted,
   input  logic                  rsp_dropped,
   input  logic [TIME_W-1:0]     rsp_gap_max,
   input  logic [VOL_W-1:0]      rsp_volume_sum,
   input  logic [PRICE_W-1:0]    rsp_price_peak,
   input  logic [NOTIONAL_W-1:0] rsp_notional_sum,
   input  logic                  rsp_overflowed,
   output int unsigned           fail_count,
   output int unsigned           pending_count
);

   // one result word as the block should report it
   typedef struct packed {
      logic [RSP_SLOT_W-1:0] slot;
      logic                  inserted;
      logic                  dropped;
      logic [TIME_W-1:0]     gap_max;
      logic [VOL_W-1:0]      volume_sum;
      logic [PRICE_W-1:0]    price_peak;
      logic [NOTIONAL_W-1:0] notional_sum;
      logic                  overflowed;
   } symbol_stats_type;

   symbol_stats_type stats_due [$];

   // shadow symbol table, entries below tab_used are live
   logic [KEY_W-1:0]      tab_key      [MAX_SYMBOLS];
   logic [TIME_W-1:0]     tab_last     [MAX_SYMBOLS];
   logic [TIME_W-1:0]     tab_gap      [MAX_SYMBOLS];
   logic [VOL_W-1:0]      tab_volume   [MAX_SYMBOLS];
   logic [PRICE_W-1:0]    tab_peak     [MAX_SYMBOLS];
   logic [NOTIONAL_W-1:0] tab_notional [MAX_SYMBOLS];
   logic                  tab_ovf      [MAX_SYMBOLS];
   int unsigned           tab_used = 0;
   int unsigned           error_total = 0;

   // apply one trade to the shadow table and build its result word
   function automatic symbol_stats_type fold_trade(input logic [TIME_W-1:0]  t,
                                                   input logic [KEY_W-1:0]   k,
                                                   input logic [QTY_W-1:0]   q,
                                                   input logic [PRICE_W-1:0] p);
      symbol_stats_type      w;
      logic [NOTIONAL_W-1:0] prod;
      logic [VOL_W:0]        vol_next;
      logic [NOTIONAL_W:0]   notional_next;
      int                    hit;
      int                    i;
      int                    s;
      w = '0;
      prod = NOTIONAL_W'(q) * NOTIONAL_W'(p);
      hit = -1;
      // lowest matching entry wins
      for (i = 0; i < tab_used && hit < 0; i++) begin
         if (tab_key[i] == k) hit = i;
      end
      s = -1;
      if (hit >= 0) begin
         // time going backwards counts as no gap, timestamp still replaced
         if (t >= tab_last[hit] && (t - tab_last[hit]) > tab_gap[hit]) begin
            tab_gap[hit] = t - tab_last[hit];
         end
         vol_next = {1'b0, tab_volume[hit]} + (VOL_W + 1)'(q);
         if (vol_next[VOL_W]) begin
            tab_volume[hit] = '1;
            tab_ovf[hit] = 1'b1;
         end else begin
            tab_volume[hit] = vol_next[VOL_W-1:0];
         end
         notional_next = {1'b0, tab_notional[hit]} + {1'b0, prod};
         if (notional_next[NOTIONAL_W]) begin
            tab_notional[hit] = '1;
            tab_ovf[hit] = 1'b1;
         end else begin
            tab_notional[hit] = notional_next[NOTIONAL_W-1:0];
         end
         if (p > tab_peak[hit]) tab_peak[hit] = p;
         tab_last[hit] = t;
         s = hit;
      end else if (tab_used >= MAX_SYMBOLS) begin
         // table full: trade ignored, all other fields zero
         w.dropped = 1'b1;
      end else begin
         s = tab_used;
         tab_key[s] = k;
         tab_last[s] = t;
         tab_gap[s] = '0;
         tab_volume[s] = VOL_W'(q);
         tab_peak[s] = p;
         tab_notional[s] = prod;
         tab_ovf[s] = 1'b0;
         tab_used++;
         w.inserted = 1'b1;
      end
      if (s >= 0) begin
         w.slot = RSP_SLOT_W'(s);
         w.gap_max = tab_gap[s];
         w.volume_sum = tab_volume[s];
         w.price_peak = tab_peak[s];
         w.notional_sum = tab_notional[s];
         w.overflowed = tab_ovf[s];
      end
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         error_total++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // watch both channels on every rising edge
   always @(posedge clock) begin
      symbol_stats_type want;
      if (reset) begin
         tab_used = 0;
         stats_due.delete();
         error_total = 0;
      end else begin
         // result side first: a word leaving now belongs to an earlier trade
         if (rsp_strobe) begin
            if (stats_due.size() == 0) begin
               error_total++;
               $display("%0t: unexpected result word, expected none, actual slot %0h",
                        $time, rsp_slot);
            end else begin
               want = stats_due.pop_front();
               check_field("slot", 64'(want.slot), 64'(rsp_slot));
               check_field("inserted", 64'(want.inserted), 64'(rsp_inserted));
               check_field("dropped", 64'(want.dropped), 64'(rsp_dropped));
               check_field("gap_max", 64'(want.gap_max), 64'(rsp_gap_max));
               check_field("volume_sum", 64'(want.volume_sum), 64'(rsp_volume_sum));
               check_field("price_peak", 64'(want.price_peak), 64'(rsp_price_peak));
               check_field("notional_sum", want.notional_sum, rsp_notional_sum);
               check_field("overflowed", 64'(want.overflowed), 64'(rsp_overflowed));
            end
         end
         // trade side
         if (start && !busy) begin
            stats_due.insert(stats_due.size(),
                             fold_trade(req_trade_time, req_ticker, req_quantity,
                                        req_unit_price));
         end
      end
      fail_count <= error_total;
      pending_count <= stats_due.size();
   end

endmodule

@@ tb/sv/per_symbol_trade_aggregator_tb.sv @@
// testbench top for the trade aggregator: clock, reset, trade stimulus and verdict
`timescale 1ns / 1ps

module per_symbol_trade_aggregator_tb;
   import pta_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [TIME_W-1:0]     req_trade_time = '0;
   logic [KEY_W-1:0]      req_ticker = '0;
   logic [QTY_W-1:0]      req_quantity = '0;
   logic [PRICE_W-1:0]    req_unit_price = '0;
   logic                  rsp_strobe;
   logic [RSP_SLOT_W-1:0] rsp_slot;
   logic                  rsp_inserted;
   logic                  rsp_dropped;
   logic [TIME_W-1:0]     rsp_gap_max;
   logic [VOL_W-1:0]      rsp_volume_sum;
   logic [PRICE_W-1:0]    rsp_price_peak;
   logic [NOTIONAL_W-1:0] rsp_notional_sum;
   logic                  rsp_overflowed;
   int unsigned           fail_count;
   int unsigned           pending_count;

   // tickers sent so far, in order of first use
   bit                    seen_ticker [int unsigned];
   logic [KEY_W-1:0]      ticker_list [$];
   logic [TIME_W-1:0]     feed_clock = '0;
   bit                    steady = 1'b0;
   bit                    gapless = 1'b0;
   int unsigned           sent_words = 0;

   always #10 clock = ~clock;

   per_symbol_trade_aggregator uut (.*);

   per_symbol_trade_aggregator_checker stats_monitor (.*);

   // trade clock: mostly small steps, sometimes jumps, steps back or wide gaps
   function automatic logic [TIME_W-1:0] next_time();
      case ($urandom_range(0, 11))
         0: feed_clock = TIME_W'({$urandom, $urandom});
         1: feed_clock = feed_clock - $urandom_range(1, 5000);
         2: feed_clock = feed_clock + (TIME_W'({$urandom, $urandom}) >> $urandom_range(0, 40));
         default: feed_clock = feed_clock + $urandom_range(0, 2000);
      endcase
      return feed_clock;
   endfunction

   function automatic logic [QTY_W-1:0] rand_amount();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3, 4: return $urandom_range(1, 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] fresh_ticker();
      logic [KEY_W-1:0] k;
      do k = KEY_W'($urandom); while (seen_ticker.exists(k));
      return k;
   endfunction

   // offer one trade word, after a random idle unless steady or gapless, and hold it until taken
   task automatic send_trade(input logic [TIME_W-1:0]  t,
                             input logic [KEY_W-1:0]   k,
                             input logic [QTY_W-1:0]   q,
                             input logic [PRICE_W-1:0] p);
      int unsigned idle;
      if (sent_words % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      idle = (steady || gapless) ? 0 : $urandom_range(0, 14);
      if (idle != 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start <= 1'b1;
      req_trade_time <= t;
      req_ticker <= k;
      req_quantity <= q;
      req_unit_price <= p;
      do @(posedge clock); while (busy);
      sent_words++;
      if (!seen_ticker.exists(k)) begin
         seen_ticker[k] = 1'b1;
         ticker_list.insert(ticker_list.size(), k);
      end
   endtask

   // hold off until every pending result word has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] any_known();
      return ticker_list[$urandom_range(0, ticker_list.size() - 1)];
   endfunction

   initial begin
      logic [KEY_W-1:0] pool [12];
      logic [KEY_W-1:0] k;
      int unsigned      n;
      int unsigned      waited;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // field extremes, notional saturation, time going backwards
      send_trade('0, '0, '0, '0);
      send_trade('1, '0, '1, '1);
      send_trade(48'd5, '0, '1, '1);
      send_trade(48'd9, '0, 32'd1, 32'd1);
      send_trade('1, '1, '1, '1);
      send_trade('0, '1, '0, '0);
      send_trade(48'd100, '1, 32'd3, 32'd7);
      // zero gap, lower price, gap wider than 32 bits
      send_trade(48'd1000, "ABC", 32'd10, 32'd50);
      send_trade(48'd1000, "ABC", 32'd1, 32'd40);
      send_trade(48'h0100_0000_03E8, "ABC", 32'd5, 32'd60);
      send_trade(48'h0100_0000_03E9, "ABC", '1, 32'd1);
      send_trade(48'd7, "XYZ", '1, '0);
      send_trade(48'd8, "XYZ", '0, '1);
      drain_results();

      // one symbol hit back to back with full-size trades at price zero
      gapless = 1'b1;
      for (n = 0; n < 40; n++) send_trade(next_time(), "VOL", '1, '0);
      gapless = 1'b0;
      drain_results();

      // small pool of symbols hit many times
      for (n = 0; n < 12; n++) begin
         pool[n] = fresh_ticker();
         send_trade(next_time(), pool[n], rand_amount(), rand_amount());
      end
      for (n = 0; n < 200; n++) begin
         send_trade(next_time(), pool[$urandom_range(0, 11)], rand_amount(), rand_amount());
      end
      drain_results();

      // fill the table with new symbols mixed with known ones
      while (ticker_list.size() < MAX_SYMBOLS) begin
         if ($urandom_range(0, 4) == 0) k = any_known();
         else k = fresh_ticker();
         send_trade(next_time(), k, rand_amount(), rand_amount());
      end
      drain_results();

      // table full: new symbols dropped, known ones still updated
      for (n = 0; n < 300; n++) begin
         if ($urandom_range(0, 1) == 0) k = any_known();
         else k = fresh_ticker();
         send_trade(next_time(), k, rand_amount(), rand_amount());
      end

      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (pending_count != 0) $display("%0t: pending result words, expected 0, actual %0d",
                                       $time, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("per_symbol_trade_aggregator_tb: done, clean");
      end else begin
         $display("per_symbol_trade_aggregator_tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400_000_000;
      $display("per_symbol_trade_aggregator_tb: done, errors");
      $finish;
   end

endmodule

@@ per_symbol_trade_aggregator.f @@
hdl/pta_pkg.sv
hdl/pta_ram.sv
hdl/pta_stat_update.sv
hdl/per_symbol_trade_aggregator.sv
tb/sv/per_symbol_trade_aggregator_checker.sv
tb/sv/per_symbol_trade_aggregator_tb.sv
